@@ rtl/u8bc_pkg.sv @@
// ----------------------------------------------------------------------------
// u8bc_pkg
// Shared types, constants and helper functions for the UTF-8 scalar counter.
// ----------------------------------------------------------------------------
package u8bc_pkg;

    localparam int COUNT_WIDTH_DEF = 12;
    localparam int REG_W           = 12;
    localparam int BYTE_W          = 8;
    localparam int APB_ADDR_W      = 3;
    localparam int APB_DATA_W      = 32;
    localparam int S_TDATA_W       = 8;
    localparam int M_TDATA_W       = 16;
    localparam int M_TUSER_W       = 2;
    localparam int Q_DEPTH         = 2;

    localparam logic [REG_W-1:0] MIN_RESET = REG_W'(1);
    localparam logic [REG_W-1:0] MAX_RESET = REG_W'(64);

    localparam logic [BYTE_W-1:0] B_ASCII_MAX  = 8'h7F;
    localparam logic [BYTE_W-1:0] B_LEAD2_LO   = 8'hC2;
    localparam logic [BYTE_W-1:0] B_LEAD2_HI   = 8'hDF;
    localparam logic [BYTE_W-1:0] B_LEAD3_LO   = 8'hE0;
    localparam logic [BYTE_W-1:0] B_LEAD3_HI   = 8'hEF;
    localparam logic [BYTE_W-1:0] B_LEAD4_LO   = 8'hF0;
    localparam logic [BYTE_W-1:0] B_LEAD4_HI   = 8'hF4;
    localparam logic [BYTE_W-1:0] B_CONT_MASK  = 8'hC0;
    localparam logic [BYTE_W-1:0] B_CONT_PAT   = 8'h80;
    localparam logic [BYTE_W-1:0] B_LIM_A0     = 8'hA0;
    localparam logic [BYTE_W-1:0] B_LEAD_ED    = 8'hED;
    localparam logic [BYTE_W-1:0] B_LIM_90     = 8'h90;

    typedef enum logic [2:0] {
        CLS_NONE,
        CLS_ASCII,
        CLS_LEAD,
        CLS_CONT,
        CLS_BAD
    } t_cls;

    typedef enum logic [2:0] {
        RULE_NONE,
        RULE_MIN_A0,
        RULE_BELOW_A0,
        RULE_MIN_90,
        RULE_BELOW_90
    } t_rule;

    typedef enum logic {
        REG_MIN_SCALARS = 1'b0,
        REG_MAX_SCALARS = 1'b1
    } t_reg_idx;

    // one classified byte as it travels from front to back
    typedef struct packed {
        t_cls       cls;
        logic [1:0] pend;
        t_rule      rule;
        logic       ge_a0;
        logic       ge_90;
        logic       last;
    } t_item;

    function automatic t_item classify(logic [BYTE_W-1:0] b, logic no_byte, logic last);
        t_item it;
        it.last  = last;
        it.ge_a0 = (b >= B_LIM_A0);
        it.ge_90 = (b >= B_LIM_90);
        it.pend  = 2'd0;
        it.rule  = RULE_NONE;
        it.cls   = CLS_BAD;
        if (no_byte) begin
            it.cls = CLS_NONE;
        end else if (b <= B_ASCII_MAX) begin
            it.cls = CLS_ASCII;
        end else if ((b & B_CONT_MASK) == B_CONT_PAT) begin
            it.cls = CLS_CONT;
        end else if (b >= B_LEAD2_LO && b <= B_LEAD2_HI) begin
            it.cls  = CLS_LEAD;
            it.pend = 2'd1;
        end else if (b >= B_LEAD3_LO && b <= B_LEAD3_HI) begin
            it.cls  = CLS_LEAD;
            it.pend = 2'd2;
            if (b == B_LEAD3_LO) begin
                it.rule = RULE_MIN_A0;
            end else if (b == B_LEAD_ED) begin
                it.rule = RULE_BELOW_A0;
            end
        end else if (b >= B_LEAD4_LO && b <= B_LEAD4_HI) begin
            it.cls  = CLS_LEAD;
            it.pend = 2'd3;
            if (b == B_LEAD4_LO) begin
                it.rule = RULE_MIN_90;
            end else if (b == B_LEAD4_HI) begin
                it.rule = RULE_BELOW_90;
            end
        end
        return it;
    endfunction

    function automatic logic rule_ok(t_rule r, logic ge_a0, logic ge_90);
        logic ok;
        case (r)
            RULE_MIN_A0:   ok = ge_a0;
            RULE_BELOW_A0: ok = !ge_a0;
            RULE_MIN_90:   ok = ge_90;
            RULE_BELOW_90: ok = !ge_90;
            default:       ok = 1'b1;
        endcase
        return ok;
    endfunction

endpackage

@@ rtl/u8bc_front.sv @@
// ----------------------------------------------------------------------------
// u8bc_front
// Accepts input transactions, classifies each byte and queues the result
// for the back end.
// ----------------------------------------------------------------------------
module u8bc_front (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_s_tvalid,
    output logic                          o_s_tready,
    input  logic [u8bc_pkg::S_TDATA_W-1:0] i_s_tdata,  // [7:0] text_byte
    input  logic                          i_s_tuser,  // [0] no_byte
    input  logic                          i_s_tlast,
    output logic                          o_q_valid,
    output u8bc_pkg::t_item               o_q_item,
    input  logic                          i_q_pop
);
    import u8bc_pkg::*;

    localparam int PTR_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
    localparam int CNT_W = $clog2(Q_DEPTH + 1);

    t_item              r_q [Q_DEPTH];
    logic [PTR_W-1:0]   r_wp;
    logic [PTR_W-1:0]   r_rp;
    logic [CNT_W-1:0]   r_cnt;
    logic               push;
    logic               pop;

    assign o_s_tready = (r_cnt != CNT_W'(Q_DEPTH));
    assign push       = i_s_tvalid && o_s_tready;
    assign o_q_valid  = (r_cnt != '0);
    assign pop        = i_q_pop && o_q_valid;
    assign o_q_item   = r_q[r_rp];

    function automatic logic [PTR_W-1:0] ptr_inc(logic [PTR_W-1:0] p);
        return (p == PTR_W'(Q_DEPTH - 1)) ? '0 : p + PTR_W'(1);
    endfunction

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wp] <= classify(i_s_tdata, i_s_tuser, i_s_tlast);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (push) begin
                r_wp <= ptr_inc(r_wp);
            end
            if (pop) begin
                r_rp <= ptr_inc(r_rp);
            end
            if (push && !pop) begin
                r_cnt <= r_cnt + CNT_W'(1);
            end else if (pop && !push) begin
                r_cnt <= r_cnt - CNT_W'(1);
            end
        end
    end

endmodule

@@ rtl/u8bc_back.sv @@
// ----------------------------------------------------------------------------
// u8bc_back
// Runs the UTF-8 sequence checker and scalar counter on classified bytes and
// holds the end-of-string report in an output register.
// ----------------------------------------------------------------------------
module u8bc_back #(
    parameter int COUNT_WIDTH = u8bc_pkg::COUNT_WIDTH_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_q_valid,
    input  u8bc_pkg::t_item                i_q_item,
    output logic                           o_q_pop,
    input  logic [u8bc_pkg::REG_W-1:0]     i_min_scalars,
    input  logic [u8bc_pkg::REG_W-1:0]     i_max_scalars,
    output logic                           o_m_tvalid,
    input  logic                           i_m_tready,
    output logic [u8bc_pkg::M_TDATA_W-1:0] o_m_tdata,  // [11:0] scalar_count
    output logic [u8bc_pkg::M_TUSER_W-1:0] o_m_tuser   // [0] well_formed, [1] in_bounds
);
    import u8bc_pkg::*;

    localparam int CMP_W = (COUNT_WIDTH > REG_W) ? COUNT_WIDTH : REG_W;

    logic [1:0]             r_pend;
    t_rule                  r_rule;
    logic                   r_err;
    logic [COUNT_WIDTH-1:0] r_count;

    logic [1:0]             n_pend;
    t_rule                  n_rule;
    logic                   n_err;
    logic [COUNT_WIDTH-1:0] n_count;
    logic                   bump;

    logic                   r_out_valid;
    logic [REG_W-1:0]       r_out_count;
    logic                   r_out_wf;
    logic                   r_out_inb;

    logic                   fin_wf;
    logic                   fin_inb;
    logic [CMP_W-1:0]       count_ext;

    // a last item may only go when the output slot is free or draining
    assign o_q_pop = i_q_valid && (!i_q_item.last || !r_out_valid || i_m_tready);

    always_comb begin
        n_pend = r_pend;
        n_rule = r_rule;
        n_err  = r_err;
        bump   = 1'b0;
        if (i_q_item.cls != CLS_NONE && !r_err) begin
            if (r_pend == 2'd0) begin
                case (i_q_item.cls)
                    CLS_ASCII: bump = 1'b1;
                    CLS_LEAD: begin
                        n_pend = i_q_item.pend;
                        n_rule = i_q_item.rule;
                    end
                    default:   n_err = 1'b1;
                endcase
            end else if (i_q_item.cls == CLS_CONT &&
                         rule_ok(r_rule, i_q_item.ge_a0, i_q_item.ge_90)) begin
                n_rule = RULE_NONE;
                n_pend = r_pend - 2'd1;
                bump   = (r_pend == 2'd1);
            end else begin
                n_err = 1'b1;
            end
        end
        n_count = (bump && r_count != {COUNT_WIDTH{1'b1}}) ?
                  r_count + COUNT_WIDTH'(1) : r_count;
    end

    // open sequence at the end of the string counts as an error
    assign count_ext = CMP_W'(n_count);
    assign fin_wf    = !n_err && (n_pend == 2'd0);
    assign fin_inb   = fin_wf && (count_ext >= CMP_W'(i_min_scalars)) &&
                       (count_ext <= CMP_W'(i_max_scalars));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend  <= 2'd0;
            r_rule  <= RULE_NONE;
            r_err   <= 1'b0;
            r_count <= '0;
        end else if (o_q_pop) begin
            if (i_q_item.last) begin
                r_pend  <= 2'd0;
                r_rule  <= RULE_NONE;
                r_err   <= 1'b0;
                r_count <= '0;
            end else begin
                r_pend  <= n_pend;
                r_rule  <= n_rule;
                r_err   <= n_err;
                r_count <= n_count;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (o_q_pop && i_q_item.last) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_q_pop && i_q_item.last) begin
            r_out_count <= count_ext[REG_W-1:0];
            r_out_wf    <= fin_wf;
            r_out_inb   <= fin_inb;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = M_TDATA_W'(r_out_count);
    assign o_m_tuser  = {r_out_inb, r_out_wf};

endmodule

@@ rtl/utf8_bounded_scalar_counter_core.sv @@
// ----------------------------------------------------------------------------
// utf8_bounded_scalar_counter_core
// Strict UTF-8 checker with saturating scalar count and a bounds check,
// reported once per string on the item marked last.
// ----------------------------------------------------------------------------
//  channel   | direction | payload
//  s_axis    | in        | tdata[7:0] text_byte, tuser[0] no_byte, tlast last
//  m_axis    | out       | tdata[11:0] scalar_count, tuser[0] well_formed,
//            |           | tuser[1] in_bounds
//  apb       | in/out    | 0x0 min_scalars, 0x4 max_scalars (12 bits each)
//
//  One byte per cycle sustained while no last item waits on a stalled report;
//  the checker state update in the back end is the only per-byte loop.
//  A last transaction is queued, and its report is registered when it is popped.
//  A two-entry queue separates input and back end; an output stall holds
//  only last items, plain bytes keep draining into the checker.
//  Synchronous reset clears queue, checker state and the output valid;
//  no clearing pass.
// ----------------------------------------------------------------------------
module utf8_bounded_scalar_counter_core #(
    parameter int COUNT_WIDTH = u8bc_pkg::COUNT_WIDTH_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_s_tvalid,
    output logic                            o_s_tready,
    input  logic [u8bc_pkg::S_TDATA_W-1:0]  i_s_tdata,  // [7:0] text_byte
    input  logic                            i_s_tuser,  // [0] no_byte
    input  logic                            i_s_tlast,
    output logic                            o_m_tvalid,
    input  logic                            i_m_tready,
    output logic [u8bc_pkg::M_TDATA_W-1:0]  o_m_tdata,  // [11:0] scalar_count
    output logic [u8bc_pkg::M_TUSER_W-1:0]  o_m_tuser,  // [0] well_formed, [1] in_bounds
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [u8bc_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [u8bc_pkg::APB_DATA_W-1:0] pwdata,
    output logic [u8bc_pkg::APB_DATA_W-1:0] prdata,
    output logic                            pready
);
    import u8bc_pkg::*;

    logic [REG_W-1:0] r_min_scalars;
    logic [REG_W-1:0] r_max_scalars;
    t_reg_idx         reg_idx;
    logic             reg_wr;

    logic             q_valid;
    t_item            q_item;
    logic             q_pop;

    // register index sits above the byte offset
    assign reg_idx = t_reg_idx'(paddr[APB_ADDR_W-1]);
    assign reg_wr  = psel && penable && pwrite && pready;
    assign pready  = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_scalars <= MIN_RESET;
            r_max_scalars <= MAX_RESET;
        end else if (reg_wr) begin
            case (reg_idx)
                REG_MIN_SCALARS: r_min_scalars <= pwdata[REG_W-1:0];
                REG_MAX_SCALARS: r_max_scalars <= pwdata[REG_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_MIN_SCALARS: prdata = APB_DATA_W'(r_min_scalars);
            REG_MAX_SCALARS: prdata = APB_DATA_W'(r_max_scalars);
            default:         prdata = '0;
        endcase
    end

    u8bc_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .i_s_tlast  (i_s_tlast),
        .o_q_valid  (q_valid),
        .o_q_item   (q_item),
        .i_q_pop    (q_pop)
    );

    u8bc_back #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_q_valid     (q_valid),
        .i_q_item      (q_item),
        .o_q_pop       (q_pop),
        .i_min_scalars (r_min_scalars),
        .i_max_scalars (r_max_scalars),
        .o_m_tvalid    (o_m_tvalid),
        .i_m_tready    (i_m_tready),
        .o_m_tdata     (o_m_tdata),
        .o_m_tuser     (o_m_tuser)
    );

endmodule

@@ rtl/u8bc_checker.sv @@
// ----------------------------------------------------------------------------
// u8bc_checker
// Port-level checks for the UTF-8 scalar counter, bound to the top level.
// ----------------------------------------------------------------------------
module u8bc_checker (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            o_s_tready,
    input logic                            o_m_tvalid,
    input logic                            i_m_tready,
    input logic [u8bc_pkg::M_TDATA_W-1:0]  o_m_tdata,
    input logic [u8bc_pkg::M_TUSER_W-1:0]  o_m_tuser,
    input logic [u8bc_pkg::APB_DATA_W-1:0] prdata,
    input logic                            pready
);
    import u8bc_pkg::*;

    // stalled report holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=>
            o_m_tvalid && $stable(o_m_tdata) && $stable(o_m_tuser))
        else $error("report changed while stalled");

    // a string in bounds must also be well formed
    a_inb_wf: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (o_m_tuser[0] || !o_m_tuser[1]))
        else $error("in_bounds without well_formed");

    // right after reset: no report pending, input open
    a_post_reset: assert property (@(posedge i_clk)
        $rose(i_rst_n) |-> (!o_m_tvalid && o_s_tready))
        else $error("not idle after reset");

    // registers are 12 bits, read data above them is zero, no wait states
    a_apb_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pready && (prdata[APB_DATA_W-1:REG_W] == '0))
        else $error("bad APB read data or wait state");

endmodule

bind utf8_bounded_scalar_counter_core u8bc_checker u_u8bc_checker (.*);

@@ dv/tb_utf8_bounded_scalar_counter_core.sv @@
// ----------------------------------------------------------------------------
// tb_utf8_bounded_scalar_counter_core
// Self-checking bench for the UTF-8 scalar counter. Byte strings go into the
// input stream from a queue, and an internal checker tracks sequence state,
// sticky errors and the saturating count to predict each end-of-string report.
// Reports are compared field by field. Bounds registers are changed over APB
// between phases; random gaps are put on the input, random back-pressure on the output.
// ----------------------------------------------------------------------------
module tb_utf8_bounded_scalar_counter_core;
    timeunit 1ns;
    timeprecision 1ps;

    import u8bc_pkg::*;

    localparam int unsigned LONG_HOLD = 400;

    typedef struct packed {
        logic [7:0] text;
        logic       no_byte;
        logic       last;
    } t_byte_item;

    typedef struct packed {
        logic [REG_W-1:0] count;
        logic             wf;
        logic             ib;
    } t_report;

    logic clk;
    logic rst_n = 1'b0;

    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [S_TDATA_W-1:0]   s_tdata  = '0;
    logic                   s_tuser  = 1'b0;
    logic                   s_tlast  = 1'b0;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [M_TDATA_W-1:0]   m_tdata;
    logic [M_TUSER_W-1:0]   m_tuser;
    logic                   psel    = 1'b0;
    logic                   penable = 1'b0;
    logic                   pwrite  = 1'b0;
    logic [APB_ADDR_W-1:0]  paddr   = '0;
    logic [APB_DATA_W-1:0]  pwdata  = '0;
    logic [APB_DATA_W-1:0]  prdata;
    logic                   pready;

    utf8_bounded_scalar_counter_core uut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .i_s_tdata  (s_tdata),
        .i_s_tuser  (s_tuser),
        .i_s_tlast  (s_tlast),
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (m_tdata),
        .o_m_tuser  (m_tuser),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    // stimulus and expectation stores
    t_byte_item  pending_bytes[$];
    t_report     expected_reports[$];
    t_byte_item  cur_item;

    // checker copy of the string state and bounds
    logic [1:0]       seq_left    = '0;
    t_rule            seq_rule    = RULE_NONE;
    logic             str_bad     = 1'b0;
    logic [REG_W-1:0] str_scalars = '0;
    logic [REG_W-1:0] cfg_min     = MIN_RESET;
    logic [REG_W-1:0] cfg_max     = MAX_RESET;

    // handshake bookkeeping between the clocked processes
    bit          s_busy    = 1'b0;
    bit          in_taken  = 1'b0;
    bit          out_taken = 1'b0;
    bit          in_calm   = 1'b1;
    bit          out_calm  = 1'b1;
    bit          hold_req  = 1'b0;
    int unsigned in_gap    = 0;
    int unsigned out_stall = 0;
    int unsigned hold_left = 0;

    int unsigned n_queued   = 0;
    int unsigned n_accepted = 0;
    int unsigned n_strings  = 0;
    int unsigned n_wf       = 0;
    int unsigned n_inb      = 0;
    int unsigned n_in_stall = 0;
    int unsigned n_cfg      = 0;
    int unsigned n_errors   = 0;

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial begin
        #4ms;
        $display("Timeout with %0d bytes and %0d reports outstanding",
                 n_queued - n_accepted, expected_reports.size());
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    task automatic report_mismatch(string what, int unsigned got, int unsigned want);
        $display("MISMATCH %s: got %0d expected %0d at %0t", what, got, want, $realtime);
        n_errors++;
    endtask

    // ------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------
    function automatic logic second_ok(t_rule r, logic [7:0] b);
        case (r)
            RULE_MIN_A0:   second_ok = (b >= B_LIM_A0);
            RULE_BELOW_A0: second_ok = (b < B_LIM_A0);
            RULE_MIN_90:   second_ok = (b >= B_LIM_90);
            RULE_BELOW_90: second_ok = (b < B_LIM_90);
            default:       second_ok = 1'b1;
        endcase
    endfunction

    task automatic bump_scalars();
        if (str_scalars != '1)
            str_scalars++;
    endtask

    task automatic utf8_track(logic [7:0] b);
        if (str_bad)
            return;
        if (seq_left == 2'd0) begin
            if (b <= B_ASCII_MAX) begin
                bump_scalars();
            end else if (b >= B_LEAD2_LO && b <= B_LEAD2_HI) begin
                seq_left = 2'd1;
                seq_rule = RULE_NONE;
            end else if (b >= B_LEAD3_LO && b <= B_LEAD3_HI) begin
                seq_left = 2'd2;
                seq_rule = (b == B_LEAD3_LO) ? RULE_MIN_A0 :
                           (b == B_LEAD_ED)  ? RULE_BELOW_A0 : RULE_NONE;
            end else if (b >= B_LEAD4_LO && b <= B_LEAD4_HI) begin
                seq_left = 2'd3;
                seq_rule = (b == B_LEAD4_LO) ? RULE_MIN_90 :
                           (b == B_LEAD4_HI) ? RULE_BELOW_90 : RULE_NONE;
            end else begin
                str_bad = 1'b1;
            end
        end else if ((b & B_CONT_MASK) != B_CONT_PAT || !second_ok(seq_rule, b)) begin
            str_bad = 1'b1;
        end else begin
            seq_rule = RULE_NONE;
            seq_left--;
            if (seq_left == 2'd0)
                bump_scalars();
        end
    endtask

    task automatic predict_report(t_byte_item it);
        t_report r;
        if (!it.no_byte)
            utf8_track(it.text);
        if (it.last) begin
            // an open sequence at the end of the string is cut off
            if (seq_left != 2'd0)
                str_bad = 1'b1;
            r.count = str_scalars;
            r.wf    = !str_bad;
            r.ib    = !str_bad && str_scalars >= cfg_min && str_scalars <= cfg_max;
            expected_reports.insert(expected_reports.size(), r);
            seq_left    = '0;
            seq_rule    = RULE_NONE;
            str_bad     = 1'b0;
            str_scalars = '0;
        end
    endtask

    // ------------------------------------------------------------------
    // Input driver
    // ------------------------------------------------------------------
    always @(negedge clk) begin
        if (!rst_n) begin
            s_tvalid <= 1'b0;
        end else begin
            if (in_taken) begin
                in_taken = 1'b0;
                s_busy   = 1'b0;
                in_gap   = in_calm ? 0 : $urandom_range(0, 19);
            end
            if (!s_busy) begin
                if (in_gap != 0) begin
                    in_gap--;
                    s_tvalid <= 1'b0;
                end else if (pending_bytes.size() != 0) begin
                    cur_item = pending_bytes.pop_front();
                    s_tdata  <= cur_item.text;
                    s_tuser  <= cur_item.no_byte;
                    s_tlast  <= cur_item.last;
                    s_tvalid <= 1'b1;
                    s_busy   = 1'b1;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Output receiver: per-report stall plus an optional long hold-off
    // ------------------------------------------------------------------
    always @(negedge clk) begin
        if (hold_req) begin
            hold_left = LONG_HOLD;
            hold_req  = 1'b0;
        end
        if (out_taken) begin
            out_taken = 1'b0;
            out_stall = out_calm ? 0 : $urandom_range(0, 19);
        end
        if (hold_left != 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else if (out_stall != 0) begin
            if (m_tvalid)
                out_stall--;
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    // ------------------------------------------------------------------
    // Monitor
    // ------------------------------------------------------------------
    always @(posedge clk) begin
        t_report want;
        if (rst_n) begin
            if (s_tvalid && !s_tready)
                n_in_stall++;
            if (s_tvalid && s_tready) begin
                predict_report(cur_item);
                in_taken = 1'b1;
                n_accepted++;
            end
            if (m_tvalid && m_tready) begin
                out_taken = 1'b1;
                if (expected_reports.size() == 0) begin
                    report_mismatch("report with no string pending, scalar_count",
                                    m_tdata[REG_W-1:0], 0);
                end else begin
                    want = expected_reports.pop_front();
                    n_strings++;
                    if (want.wf) n_wf++;
                    if (want.ib) n_inb++;
                    if (m_tdata[REG_W-1:0] != want.count)
                        report_mismatch("scalar_count", m_tdata[REG_W-1:0], want.count);
                    if (m_tuser[0] != want.wf)
                        report_mismatch("well_formed", m_tuser[0], want.wf);
                    if (m_tuser[1] != want.ib)
                        report_mismatch("in_bounds", m_tuser[1], want.ib);
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Register access
    // ------------------------------------------------------------------
    task automatic apb_write(t_reg_idx idx, logic [REG_W-1:0] val);
        logic [APB_DATA_W-1:0] word;
        word = $urandom;
        word[REG_W-1:0] = val;  // upper bits are junk, the register keeps 12
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= word;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        if (idx == REG_MIN_SCALARS) cfg_min = val;
        else                        cfg_max = val;
        n_cfg++;
        @(negedge clk);
        pwrite  <= 1'b0;
        penable <= 1'b0;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        if (prdata[REG_W-1:0] != val)
            report_mismatch("register read back", prdata[REG_W-1:0], val);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic set_bounds(logic [REG_W-1:0] lo, logic [REG_W-1:0] hi);
        apb_write(REG_MIN_SCALARS, lo);
        apb_write(REG_MAX_SCALARS, hi);
    endtask

    // ------------------------------------------------------------------
    // String generation
    // ------------------------------------------------------------------
    task automatic queue_byte(logic [7:0] b, logic nb, logic lst);
        pending_bytes.insert(pending_bytes.size(),
                             t_byte_item'{text: b, no_byte: nb, last: lst});
        n_queued++;
    endtask

    function automatic logic [7:0] pick_edge_byte(logic [7:0] lo, logic [7:0] hi);
        case ($urandom_range(0, 3))
            0:       return lo;
            1:       return hi;
            default: return 8'($urandom_range(lo, hi));
        endcase
    endfunction

    // one well-formed scalar, boundary values favored
    task automatic make_scalar(ref logic [7:0] sb[$]);
        logic [7:0] lead;
        logic [7:0] lo;
        logic [7:0] hi;
        case ($urandom_range(0, 9))
            0, 1, 2, 3: begin
                sb.insert(sb.size(), pick_edge_byte(8'h00, B_ASCII_MAX));
            end
            4, 5: begin
                sb.insert(sb.size(), pick_edge_byte(B_LEAD2_LO, B_LEAD2_HI));
                sb.insert(sb.size(), pick_edge_byte(8'h80, 8'hBF));
            end
            6, 7: begin
                lead = pick_edge_byte(B_LEAD3_LO, B_LEAD3_HI);
                if ($urandom_range(0, 3) == 0)
                    lead = B_LEAD_ED;
                lo = (lead == B_LEAD3_LO) ? B_LIM_A0 : 8'h80;
                hi = (lead == B_LEAD_ED) ? 8'h9F : 8'hBF;
                sb.insert(sb.size(), lead);
                sb.insert(sb.size(), pick_edge_byte(lo, hi));
                sb.insert(sb.size(), pick_edge_byte(8'h80, 8'hBF));
            end
            default: begin
                lead = pick_edge_byte(B_LEAD4_LO, B_LEAD4_HI);
                lo = (lead == B_LEAD4_LO) ? B_LIM_90 : 8'h80;
                hi = (lead == B_LEAD4_HI) ? 8'h8F : 8'hBF;
                sb.insert(sb.size(), lead);
                sb.insert(sb.size(), pick_edge_byte(lo, hi));
                sb.insert(sb.size(), pick_edge_byte(8'h80, 8'hBF));
                sb.insert(sb.size(), pick_edge_byte(8'h80, 8'hBF));
            end
        endcase
    endtask

    // mostly valid strings; some get a damaged scalar, a few are pure noise
    task automatic add_string(int unsigned max_len);
        t_byte_item  s[$];
        logic [7:0]  sb[$];
        int unsigned n;
        n = $urandom_range(0, max_len);
        if ($urandom_range(0, 19) == 0) begin
            repeat ($urandom_range(1, 6))
                s.insert(s.size(), t_byte_item'{text: 8'($urandom),
                                                no_byte: ($urandom_range(0, 7) == 0),
                                                last: 1'b0});
        end else begin
            for (int unsigned i = 0; i < n; i++) begin
                if ($urandom_range(0, 11) == 0)
                    s.insert(s.size(), t_byte_item'{text: 8'($urandom), no_byte: 1'b1,
                                                    last: 1'b0});
                sb.delete();
                make_scalar(sb);
                if ($urandom_range(0, 39) == 0) begin
                    case ($urandom_range(0, 2))
                        0: sb[$urandom_range(0, sb.size() - 1)] = 8'($urandom);
                        1: if (sb.size() > 1) void'(sb.pop_back());
                        default: if (sb.size() > 1) sb[1] = 8'($urandom_range(8'h80, 8'hBF));
                    endcase
                end
                foreach (sb[k])
                    s.insert(s.size(), t_byte_item'{text: sb[k], no_byte: 1'b0,
                                                    last: 1'b0});
            end
        end
        if (s.size() == 0 || $urandom_range(0, 5) == 0)
            s.insert(s.size(), t_byte_item'{text: 8'($urandom), no_byte: 1'b1,
                                            last: 1'b1});
        else
            s[s.size() - 1].last = 1'b1;
        foreach (s[k])
            queue_byte(s[k].text, s[k].no_byte, s[k].last);
    endtask

    task automatic add_strings(int unsigned n_bytes, int unsigned max_len);
        int unsigned stop_at;
        stop_at = n_queued + n_bytes;
        while (n_queued < stop_at)
            add_string(max_len);
    endtask

    task automatic drain();
        while (!(n_accepted == n_queued && expected_reports.size() == 0))
            @(posedge clk);
        // then let the bench idle before the next phase
        repeat (4) @(posedge clk);
    endtask

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------
    initial begin
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed strings under reset bounds
        queue_byte(8'h5A, 1'b1, 1'b1);                                   // empty
        queue_byte(8'h00, 1'b0, 1'b0); queue_byte(8'h7F, 1'b0, 1'b1);
        queue_byte(8'hC2, 1'b0, 1'b0); queue_byte(8'hA5, 1'b1, 1'b0);   // gap mid-seq
        queue_byte(8'h80, 1'b0, 1'b0); queue_byte(8'hDF, 1'b0, 1'b0);
        queue_byte(8'hBF, 1'b0, 1'b1);
        queue_byte(8'h41, 1'b0, 1'b0); queue_byte(8'hE0, 1'b0, 1'b0);   // count then error
        queue_byte(8'h9F, 1'b0, 1'b1);
        queue_byte(8'hED, 1'b0, 1'b0); queue_byte(8'hA0, 1'b0, 1'b1);
        queue_byte(8'hF0, 1'b0, 1'b0); queue_byte(8'h8F, 1'b0, 1'b1);
        queue_byte(8'hF4, 1'b0, 1'b0); queue_byte(8'h90, 1'b0, 1'b1);
        queue_byte(8'hC1, 1'b0, 1'b1);                                   // bad lead
        queue_byte(8'hFF, 1'b0, 1'b0); queue_byte(8'h41, 1'b0, 1'b1);   // sticky
        queue_byte(8'hE1, 1'b0, 1'b0); queue_byte(8'h80, 1'b0, 1'b1);   // cut off
        queue_byte(8'hC2, 1'b0, 1'b0); queue_byte(8'h41, 1'b0, 1'b1);   // bad cont
        queue_byte(8'h80, 1'b0, 1'b1);                                   // stray cont
        drain();

        in_calm = 1'b0; out_calm = 1'b0;
        set_bounds(12'd0, 12'd4095);
        add_strings(300, 10);
        drain();

        in_calm = 1'b1; out_calm = 1'b0;
        set_bounds(12'd4095, 12'd0);
        add_strings(150, 10);
        drain();

        // receiver holds off while short strings keep coming
        in_calm = 1'b1; out_calm = 1'b1;
        set_bounds(12'd3, 12'd6);
        hold_req = 1'b1;
        add_strings(250, 2);
        drain();

        in_calm = 1'b0; out_calm = 1'b1;
        set_bounds(12'($urandom_range(0, 15)), 12'($urandom_range(0, 15)));
        add_strings(300, 10);
        drain();

        in_calm = 1'b0; out_calm = 1'b0;
        set_bounds(12'd0, 12'd0);
        add_strings(150, 6);
        drain();

        in_calm = 1'b0; out_calm = 1'b0;
        set_bounds(12'd2, 12'd8);
        add_strings(175, 10);
        drain();

        repeat (10) @(posedge clk);
        $display("Covered %0d bytes in %0d strings: %0d well formed, %0d in bounds.",
                 n_accepted, n_strings, n_wf, n_inb);
        $display("%0d register writes; input back-pressured for %0d cycles.",
                 n_cfg, n_in_stall);
        if (n_errors == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

@@ files.f @@
rtl/u8bc_pkg.sv
rtl/u8bc_front.sv
rtl/u8bc_back.sv
rtl/utf8_bounded_scalar_counter_core.sv
rtl/u8bc_checker.sv
dv/tb_utf8_bounded_scalar_counter_core.sv
